@@ rtl/core/lumadbf_pkg.sv @@
// Package with the shared types and constants of the luma deblocking line filter.
`default_nettype none

package lumadbf_pkg;

    localparam int PIX_W = 8;
    localparam int QP_W  = 6;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [QP_W-1:0]  qp_t;
    typedef logic [1:0]       mode_t;
    typedef logic [1:0]       grade_t;

    localparam mode_t MODE_NONE   = 2'd0;
    localparam mode_t MODE_WEAK   = 2'd1;
    localparam mode_t MODE_STRONG = 2'd2;

    localparam grade_t GRADE_NONE = 2'd0;
    localparam grade_t GRADE_LOW  = 2'd1;
    localparam grade_t GRADE_MID  = 2'd2;
    localparam grade_t GRADE_HIGH = 2'd3;

    localparam int T1_MIN       = 2;
    localparam int T2_MIN       = 4;
    localparam int T3_MIN       = 8;
    localparam int T3_MAX       = 48;
    localparam int TC_MIN       = 1;
    localparam int TC_MAX       = 10;
    localparam int DIV3_MUL     = 43;
    localparam int DIV3_SHIFT   = 7;
    localparam int TAP_OUTER    = 5;
    localparam int TAP_INNER    = 20;
    localparam int STRONG_ROUND = 16;
    localparam int WEAK_ROUND   = 4;
    localparam int PIX_MAX      = 255;

    typedef struct packed {
        pixel_t p3;
        pixel_t p2;
        pixel_t p1;
        pixel_t p0;
        pixel_t q0;
        pixel_t q1;
        pixel_t q2;
        pixel_t q3;
        qp_t    qp;
    } line_t;

    typedef struct packed {
        mode_t  mode;
        grade_t grade;
    } status_t;

    typedef struct packed {
        pixel_t  p1;
        pixel_t  p0;
        pixel_t  q0;
        pixel_t  q1;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/luma_deblock_line_filter_unit.sv @@
// Top level of the luma deblocking line filter: input register, filter logic, result register.
//
//   channel   direction   handshake                   payload
//   line      in          line_valid / line_stall     p3_in .. q3_in, quant_param
//   result    out         result_valid / result_stall p1_out .. q1_out, filter_mode, edge_grade
//
// One beat can be taken every cycle while line_stall is low; results come out in line order.
// The only path is input register, one pass of filter logic, result register.
// rst_n clears both valid flags asynchronously; payload registers are not reset.
// A result stall holds the result register, and line_stall rises only when the
// input register is full and cannot move forward.
`default_nettype none

module luma_deblock_line_filter_unit
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       line_valid,
    output       logic       line_stall,
    input  wire  logic [7:0] p3_in,
    input  wire  logic [7:0] p2_in,
    input  wire  logic [7:0] p1_in,
    input  wire  logic [7:0] p0_in,
    input  wire  logic [7:0] q0_in,
    input  wire  logic [7:0] q1_in,
    input  wire  logic [7:0] q2_in,
    input  wire  logic [7:0] q3_in,
    input  wire  logic [5:0] quant_param,
    output       logic       result_valid,
    input  wire  logic       result_stall,
    output       logic [7:0] p1_out,
    output       logic [7:0] p0_out,
    output       logic [7:0] q0_out,
    output       logic [7:0] q1_out,
    output       logic [1:0] filter_mode,
    output       logic [1:0] edge_grade
);

    logic                  in_valid_reg;
    lumadbf_pkg::line_t    in_line_reg;
    logic                  out_valid_reg;
    lumadbf_pkg::result_t  out_result_reg;
    lumadbf_pkg::result_t  out_result_next;
    logic                  out_load;
    logic                  in_load;

    assign out_load   = !out_valid_reg || !result_stall;
    assign in_load    = !in_valid_reg || out_load;
    assign line_stall = !in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= line_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && line_valid)
        begin
            in_line_reg <= '{p3: p3_in, p2: p2_in, p1: p1_in, p0: p0_in,
                             q0: q0_in, q1: q1_in, q2: q2_in, q3: q3_in,
                             qp: quant_param};
        end
        if (out_load && in_valid_reg)
        begin
            out_result_reg <= out_result_next;
        end
    end

    lumadbf_filter u_filter
    (
        .line   (in_line_reg),
        .result (out_result_next)
    );

    assign result_valid = out_valid_reg;
    assign p1_out       = out_result_reg.p1;
    assign p0_out       = out_result_reg.p0;
    assign q0_out       = out_result_reg.q0;
    assign q1_out       = out_result_reg.q1;
    assign filter_mode  = out_result_reg.status.mode;
    assign edge_grade   = out_result_reg.status.grade;

`ifndef ASSERT_OFF
    a_strong_needs_high_grade: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (filter_mode == lumadbf_pkg::MODE_STRONG))
            |-> (edge_grade == lumadbf_pkg::GRADE_HIGH))
        else $error("strong filter applied below the highest edge grade");

    a_zero_grade_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (edge_grade == lumadbf_pkg::GRADE_NONE))
            |-> (filter_mode == lumadbf_pkg::MODE_NONE))
        else $error("filter applied on an edge of grade zero");

    a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
        line_stall |=> (in_valid_reg && $stable(in_line_reg)))
        else $error("input stage changed while the line channel was stalled");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        line_stall |-> (out_valid_reg && result_stall))
        else $error("line channel stalled while the result stage could move");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lumadbf_filter.sv @@
// Edge grading, strong five-tap filter and weak clipped-delta filter for one line.
`default_nettype none

module lumadbf_filter
(
    input  wire lumadbf_pkg::line_t   line,
    output      lumadbf_pkg::result_t result
);

    function automatic lumadbf_pkg::pixel_t five_tap(
        input lumadbf_pkg::pixel_t a,
        input lumadbf_pkg::pixel_t b,
        input lumadbf_pkg::pixel_t c,
        input lumadbf_pkg::pixel_t d,
        input lumadbf_pkg::pixel_t e
    );
        logic [8:0]         cd;
        logic [8:0]         be;
        logic signed [14:0] s;
        logic signed [9:0]  sh;
        lumadbf_pkg::pixel_t r;
        cd = {1'b0, c} + {1'b0, d};
        be = {1'b0, b} + {1'b0, e};
        s  = $signed({7'b0, a})
           + $signed({6'b0, cd} * 15'(lumadbf_pkg::TAP_INNER))
           - $signed({6'b0, be} * 15'(lumadbf_pkg::TAP_OUTER))
           + $signed(15'(lumadbf_pkg::STRONG_ROUND));
        sh = s[14:5];
        if (sh < 10'sd0)
        begin
            r = '0;
        end
        else if (sh > $signed(10'(lumadbf_pkg::PIX_MAX)))
        begin
            r = lumadbf_pkg::pixel_t'(lumadbf_pkg::PIX_MAX);
        end
        else
        begin
            r = sh[7:0];
        end
        return r;
    endfunction

    function automatic lumadbf_pkg::pixel_t abs_diff(
        input lumadbf_pkg::pixel_t a,
        input lumadbf_pkg::pixel_t b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [5:0]          t1;
    logic [5:0]          t2;
    logic [5:0]          t3;
    logic [11:0]         qp_prod;
    logic [4:0]          qp_div3;
    logic [3:0]          tc;
    lumadbf_pkg::pixel_t d_edge;
    lumadbf_pkg::grade_t grade;
    logic                flat;
    logic signed [12:0]  weak_sum;
    logic signed [9:0]   weak_raw;
    logic signed [9:0]   tc_s;
    logic signed [9:0]   delta;
    logic signed [9:0]   p0_sum;
    logic signed [9:0]   q0_sum;
    lumadbf_pkg::pixel_t p0_weak;
    lumadbf_pkg::pixel_t q0_weak;

    always_comb
    begin
        t1 = ({2'b0, line.qp[5:2]} < 6'(lumadbf_pkg::T1_MIN)) ?
             6'(lumadbf_pkg::T1_MIN) : {2'b0, line.qp[5:2]};
        t2 = ({1'b0, line.qp[5:1]} < 6'(lumadbf_pkg::T2_MIN)) ?
             6'(lumadbf_pkg::T2_MIN) : {1'b0, line.qp[5:1]};
        if (line.qp < 6'(lumadbf_pkg::T3_MIN))
        begin
            t3 = 6'(lumadbf_pkg::T3_MIN);
        end
        else if (line.qp > 6'(lumadbf_pkg::T3_MAX))
        begin
            t3 = 6'(lumadbf_pkg::T3_MAX);
        end
        else
        begin
            t3 = line.qp;
        end

        // Division by three through a reciprocal, exact for the whole quantizer range.
        qp_prod = {6'b0, line.qp} * 12'(lumadbf_pkg::DIV3_MUL);
        qp_div3 = qp_prod[11:lumadbf_pkg::DIV3_SHIFT];
        if (qp_div3 < 5'(lumadbf_pkg::TC_MIN))
        begin
            tc = 4'(lumadbf_pkg::TC_MIN);
        end
        else if (qp_div3 > 5'(lumadbf_pkg::TC_MAX))
        begin
            tc = 4'(lumadbf_pkg::TC_MAX);
        end
        else
        begin
            tc = qp_div3[3:0];
        end

        d_edge = abs_diff(line.p0, line.q0);
        if (d_edge < {2'b0, t1})
        begin
            grade = lumadbf_pkg::GRADE_NONE;
        end
        else if (d_edge < {2'b0, t2})
        begin
            grade = lumadbf_pkg::GRADE_LOW;
        end
        else if (d_edge < {2'b0, t3})
        begin
            grade = lumadbf_pkg::GRADE_MID;
        end
        else
        begin
            grade = lumadbf_pkg::GRADE_HIGH;
        end

        flat = (abs_diff(line.p2, line.p0) < {4'b0, tc})
            && (abs_diff(line.p3, line.p0) < {4'b0, tc})
            && (abs_diff(line.q2, line.q0) < {4'b0, tc})
            && (abs_diff(line.q3, line.q0) < {4'b0, tc});

        // The summed delta is symmetric, so one delta serves both sides.
        weak_sum = $signed({3'b0, line.p0, 2'b0})
                 + $signed({3'b0, line.q0, 2'b0})
                 - $signed({5'b0, line.p1})
                 - $signed({5'b0, line.q1})
                 + $signed(13'(lumadbf_pkg::WEAK_ROUND));
        weak_raw = weak_sum[12:3];
        tc_s     = $signed({6'b0, tc});
        if (weak_raw < -tc_s)
        begin
            delta = -tc_s;
        end
        else if (weak_raw > tc_s)
        begin
            delta = tc_s;
        end
        else
        begin
            delta = weak_raw;
        end

        p0_sum = $signed({2'b0, line.p0}) + delta;
        q0_sum = $signed({2'b0, line.q0}) + delta;
        if (p0_sum < 10'sd0)
        begin
            p0_weak = '0;
        end
        else if (p0_sum > $signed(10'(lumadbf_pkg::PIX_MAX)))
        begin
            p0_weak = lumadbf_pkg::pixel_t'(lumadbf_pkg::PIX_MAX);
        end
        else
        begin
            p0_weak = p0_sum[7:0];
        end
        if (q0_sum < 10'sd0)
        begin
            q0_weak = '0;
        end
        else if (q0_sum > $signed(10'(lumadbf_pkg::PIX_MAX)))
        begin
            q0_weak = lumadbf_pkg::pixel_t'(lumadbf_pkg::PIX_MAX);
        end
        else
        begin
            q0_weak = q0_sum[7:0];
        end

        result.p1           = line.p1;
        result.p0           = line.p0;
        result.q0           = line.q0;
        result.q1           = line.q1;
        result.status.mode  = lumadbf_pkg::MODE_NONE;
        result.status.grade = grade;
        if (grade != lumadbf_pkg::GRADE_NONE)
        begin
            if ((grade == lumadbf_pkg::GRADE_HIGH) && flat)
            begin
                result.p1          = five_tap(line.p3, line.p2, line.p1, line.p0, line.q0);
                result.p0          = five_tap(line.p2, line.p1, line.p0, line.q0, line.q1);
                result.q0          = five_tap(line.p0, line.q0, line.q1, line.q2, line.q3);
                result.q1          = five_tap(line.p1, line.q0, line.q1, line.q2, line.q3);
                result.status.mode = lumadbf_pkg::MODE_STRONG;
            end
            else
            begin
                result.p0          = p0_weak;
                result.q0          = q0_weak;
                result.status.mode = lumadbf_pkg::MODE_WEAK;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/luma_deblock_line_filter_unit_tb.sv @@
// Self-checking testbench for the luma deblocking line filter unit.
module luma_deblock_line_filter_unit_tb;

    typedef struct {
        lumadbf_pkg::line_t line;
        int unsigned        gap;
    } line_job_t;

    localparam int RANDOM_LINES = 630;
    localparam int HOLD_CYCLES  = 80;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                line_valid   = 1'b0;
    logic                line_stall;
    lumadbf_pkg::line_t  line_drv     = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                hold_off     = 1'b0;
    lumadbf_pkg::pixel_t p1_out;
    lumadbf_pkg::pixel_t p0_out;
    lumadbf_pkg::pixel_t q0_out;
    lumadbf_pkg::pixel_t q1_out;
    lumadbf_pkg::mode_t  filter_mode;
    lumadbf_pkg::grade_t edge_grade;

    line_job_t              lines_pending[$];
    lumadbf_pkg::result_t   filtered_expected[$];
    int unsigned idle_left      = 0;
    int unsigned stall_left     = 0;
    int unsigned lines_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned errors         = 0;
    int unsigned send_idle_pct[6] = '{0, 30, 0, 60, 10, 20};
    int unsigned recv_stall_pct[5] = '{15, 0, 50, 5, 30};

    luma_deblock_line_filter_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line_stall   (line_stall),
        .p3_in        (line_drv.p3),
        .p2_in        (line_drv.p2),
        .p1_in        (line_drv.p1),
        .p0_in        (line_drv.p0),
        .q0_in        (line_drv.q0),
        .q1_in        (line_drv.q1),
        .q2_in        (line_drv.q2),
        .q3_in        (line_drv.q3),
        .quant_param  (line_drv.qp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .p1_out       (p1_out),
        .p0_out       (p0_out),
        .q0_out       (q0_out),
        .q1_out       (q1_out),
        .filter_mode  (filter_mode),
        .edge_grade   (edge_grade)
    );

    always #4 clk = ~clk;

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int pixel_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic lumadbf_pkg::pixel_t five_tap(int a, int b, int c, int d, int e);
        int sum;
        sum = a - lumadbf_pkg::TAP_OUTER * b + lumadbf_pkg::TAP_INNER * c
            + lumadbf_pkg::TAP_INNER * d - lumadbf_pkg::TAP_OUTER * e
            + lumadbf_pkg::STRONG_ROUND;
        return lumadbf_pkg::pixel_t'(clamp_int(sum >>> 5, 0, lumadbf_pkg::PIX_MAX));
    endfunction

    function automatic lumadbf_pkg::result_t filter_line(lumadbf_pkg::line_t ln);
        int                   p3, p2, p1, p0, q0, q1, q2, q3, qp;
        int                   t1, t2, t3, tc, edge_step, sum, delta;
        bit                   flat;
        lumadbf_pkg::result_t r;
        p3 = ln.p3;
        p2 = ln.p2;
        p1 = ln.p1;
        p0 = ln.p0;
        q0 = ln.q0;
        q1 = ln.q1;
        q2 = ln.q2;
        q3 = ln.q3;
        qp = ln.qp;
        t1 = clamp_int(qp / 4, lumadbf_pkg::T1_MIN, 16);
        t2 = clamp_int(qp / 2, lumadbf_pkg::T2_MIN, 32);
        t3 = clamp_int(qp, lumadbf_pkg::T3_MIN, lumadbf_pkg::T3_MAX);
        tc = clamp_int(qp / 3, lumadbf_pkg::TC_MIN, lumadbf_pkg::TC_MAX);
        edge_step = pixel_gap(p0, q0);
        r.p1 = ln.p1;
        r.p0 = ln.p0;
        r.q0 = ln.q0;
        r.q1 = ln.q1;
        r.status.mode = lumadbf_pkg::MODE_NONE;
        if (edge_step < t1)
        begin
            r.status.grade = lumadbf_pkg::GRADE_NONE;
        end
        else if (edge_step < t2)
        begin
            r.status.grade = lumadbf_pkg::GRADE_LOW;
        end
        else if (edge_step < t3)
        begin
            r.status.grade = lumadbf_pkg::GRADE_MID;
        end
        else
        begin
            r.status.grade = lumadbf_pkg::GRADE_HIGH;
        end
        if (r.status.grade != lumadbf_pkg::GRADE_NONE)
        begin
            flat = pixel_gap(p2, p0) < tc && pixel_gap(p3, p0) < tc &&
                   pixel_gap(q2, q0) < tc && pixel_gap(q3, q0) < tc;
            if (r.status.grade == lumadbf_pkg::GRADE_HIGH && flat)
            begin
                r.p1 = five_tap(p3, p2, p1, p0, q0);
                r.p0 = five_tap(p2, p1, p0, q0, q1);
                r.q0 = five_tap(p0, q0, q1, q2, q3);
                r.q1 = five_tap(p1, q0, q1, q2, q3);
                r.status.mode = lumadbf_pkg::MODE_STRONG;
            end
            else
            begin
                // The same summed delta is applied on both sides of the edge.
                sum = 4 * p0 + 4 * q0 - p1 - q1 + lumadbf_pkg::WEAK_ROUND;
                delta = clamp_int(sum >>> 3, -tc, tc);
                r.p0 = lumadbf_pkg::pixel_t'(clamp_int(p0 + delta, 0, lumadbf_pkg::PIX_MAX));
                r.q0 = lumadbf_pkg::pixel_t'(clamp_int(q0 + delta, 0, lumadbf_pkg::PIX_MAX));
                r.status.mode = lumadbf_pkg::MODE_WEAK;
            end
        end
        return r;
    endfunction

    function automatic int unsigned gap_len(int unsigned pct);
        if ($urandom_range(99) >= pct)
        begin
            return 0;
        end
        if ($urandom_range(9) != 0)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 24);
    endfunction

    function automatic int near_px(int v, int r);
        return clamp_int(v + int'($urandom_range(0, 2 * r)) - r, 0, lumadbf_pkg::PIX_MAX);
    endfunction

    task automatic add_line(input int p3, input int p2, input int p1, input int p0,
                            input int q0, input int q1, input int q2, input int q3,
                            input int qp, input int unsigned gap);
        line_job_t job;
        job.line = '{p3: lumadbf_pkg::pixel_t'(p3), p2: lumadbf_pkg::pixel_t'(p2),
                     p1: lumadbf_pkg::pixel_t'(p1), p0: lumadbf_pkg::pixel_t'(p0),
                     q0: lumadbf_pkg::pixel_t'(q0), q1: lumadbf_pkg::pixel_t'(q1),
                     q2: lumadbf_pkg::pixel_t'(q2), q3: lumadbf_pkg::pixel_t'(q3),
                     qp: lumadbf_pkg::qp_t'(qp)};
        job.gap = gap;
        lines_pending.push_back(job);
    endtask

    // Line driver: a beat stays on the port until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid <= 1'b0;
            idle_left  <= 0;
        end
        else
        begin
            if (line_valid && !line_stall)
            begin
                filtered_expected.push_back(filter_line(line_drv));
                lines_accepted <= lines_accepted + 1;
            end
            if (!line_valid || !line_stall)
            begin
                if (idle_left != 0)
                begin
                    line_valid <= 1'b0;
                    idle_left  <= idle_left - 1;
                end
                else if (lines_pending.size() != 0)
                begin
                    line_drv   <= lines_pending[0].line;
                    idle_left  <= lines_pending[0].gap;
                    line_valid <= 1'b1;
                    lines_pending.pop_front();
                end
                else
                begin
                    line_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        lumadbf_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (filtered_expected.size() == 0)
                begin
                    $error("result beat arrived with no line outstanding");
                    errors++;
                end
                else
                begin
                    want = filtered_expected.pop_front();
                    if (p1_out !== want.p1)
                    begin
                        $error("p1_out: expected %0d, got %0d", want.p1, p1_out);
                        errors++;
                    end
                    if (p0_out !== want.p0)
                    begin
                        $error("p0_out: expected %0d, got %0d", want.p0, p0_out);
                        errors++;
                    end
                    if (q0_out !== want.q0)
                    begin
                        $error("q0_out: expected %0d, got %0d", want.q0, q0_out);
                        errors++;
                    end
                    if (q1_out !== want.q1)
                    begin
                        $error("q1_out: expected %0d, got %0d", want.q1, q1_out);
                        errors++;
                    end
                    if (filter_mode !== want.status.mode)
                    begin
                        $error("filter_mode: expected %0d, got %0d", want.status.mode,
                               filter_mode);
                        errors++;
                    end
                    if (edge_grade !== want.status.grade)
                    begin
                        $error("edge_grade: expected %0d, got %0d", want.status.grade,
                               edge_grade);
                        errors++;
                    end
                end
            end
            if (hold_off)
            begin
                result_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left   <= gap_len(recv_stall_pct[(results_seen / 100) % 5]);
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering lines.
    initial
    begin
        while (lines_accepted < 250)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int          total, kind, qp, tc, p0, q0, step_size, side;
        int          t1, t2, t3;
        int unsigned gap;
        int          edge_dist[6];

        // Flat and smooth lines that grade zero.
        add_line(0, 0, 0, 0, 0, 0, 0, 0, 0, gap_len(30));
        add_line(255, 255, 255, 255, 255, 255, 255, 255, 63, gap_len(30));
        // Full step with flat sides: strong filter at both quantizer extremes.
        add_line(0, 0, 0, 0, 255, 255, 255, 255, 63, gap_len(30));
        add_line(0, 0, 0, 0, 255, 255, 255, 255, 0, gap_len(30));
        // Strong filter on flat-sided lines with p1 and q1 at the opposite extreme to p0 and q0.
        add_line(0, 0, 255, 0, 255, 0, 255, 255, 63, gap_len(30));
        add_line(255, 255, 0, 255, 0, 255, 0, 0, 63, gap_len(30));
        // Top grade without flat sides falls back to the weak filter.
        add_line(100, 0, 0, 0, 200, 200, 200, 200, 63, gap_len(30));
        add_line(0, 0, 0, 200, 100, 100, 100, 100, 20, gap_len(30));
        // Weak filter clipping the pixel at zero and at full scale.
        add_line(0, 0, 255, 0, 5, 255, 0, 0, 0, gap_len(30));
        add_line(255, 255, 0, 255, 250, 0, 255, 255, 0, gap_len(30));
        add_line(9, 9, 255, 3, 0, 255, 9, 9, 0, gap_len(30));
        // Grade boundaries at a mid quantizer.
        foreach (edge_dist[i])
        begin
            edge_dist[i] = (i == 0) ? 7 : (i == 1) ? 8 : (i == 2) ? 15 :
                           (i == 3) ? 16 : (i == 4) ? 31 : 32;
            add_line(100, 100, 100, 100, 100 + edge_dist[i], 100 + edge_dist[i],
                     100 + edge_dist[i], 100 + edge_dist[i], 32, gap_len(30));
        end
        // Top-grade boundary at the largest quantizer.
        add_line(50, 50, 50, 50, 97, 97, 97, 97, 63, gap_len(30));
        add_line(50, 50, 50, 50, 98, 98, 98, 98, 63, gap_len(30));
        // Clip-limit boundaries of the division by three.
        add_line(10, 10, 10, 10, 60, 61, 60, 60, 5, gap_len(30));
        add_line(10, 11, 10, 10, 60, 61, 61, 60, 6, gap_len(30));
        add_line(10, 19, 30, 10, 60, 40, 69, 51, 30, gap_len(30));
        add_line(10, 19, 30, 10, 60, 40, 69, 51, 33, gap_len(30));

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            kind = $urandom_range(0, 9);
            qp = $urandom_range(0, 63);
            tc = clamp_int(qp / 3, lumadbf_pkg::TC_MIN, lumadbf_pkg::TC_MAX);
            gap = gap_len(send_idle_pct[(i / 100) % 6]);
            if (kind < 4)
            begin
                // Large step with sides kept flat enough for the strong filter.
                p0 = $urandom_range(0, 255);
                step_size = $urandom_range(48, 127);
                q0 = (p0 < 128) ? p0 + step_size : p0 - step_size;
                add_line(near_px(p0, tc - 1), near_px(p0, tc - 1), near_px(p0, 40), p0,
                         q0, near_px(q0, 40), near_px(q0, tc - 1), near_px(q0, tc - 1),
                         qp, gap);
            end
            else if (kind < 7)
            begin
                // Step sitting on or next to one of the grade thresholds.
                t1 = clamp_int(qp / 4, lumadbf_pkg::T1_MIN, 16);
                t2 = clamp_int(qp / 2, lumadbf_pkg::T2_MIN, 32);
                t3 = clamp_int(qp, lumadbf_pkg::T3_MIN, lumadbf_pkg::T3_MAX);
                side = $urandom_range(0, 5);
                step_size = (side == 0) ? t1 - 1 : (side == 1) ? t1 : (side == 2) ? t2 - 1 :
                            (side == 3) ? t2 : (side == 4) ? t3 - 1 : t3;
                p0 = $urandom_range(60, 190);
                q0 = $urandom_range(0, 1) ? p0 + step_size : p0 - step_size;
                add_line(near_px(p0, 12), near_px(p0, 12), near_px(p0, 60), p0,
                         q0, near_px(q0, 60), near_px(q0, 12), near_px(q0, 12), qp, gap);
            end
            else
            begin
                add_line($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), qp, gap);
            end
        end
        total = lines_pending.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (lines_accepted != total || filtered_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
